@@ rtl/hex_record_loader_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the hex record loader.
// Both forms sample on clk and are switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HEX_RECORD_LOADER_CORE_ASSERT_SVH
`define HEX_RECORD_LOADER_CORE_ASSERT_SVH

// Same-cycle implication.
`define HRL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HRL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hrl_pkg.sv @@
// ----------------------------------------------------------------------------
// hrl_pkg
// Types, codes and helpers shared by the hex record loader modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrl_pkg;

  localparam int unsigned ADDR_WIDTH_DEFAULT = 32;
  localparam int unsigned ADDR_OUT_W         = 32;
  localparam int unsigned CHAR_W             = 8;
  localparam int unsigned DATA_W             = 8;
  localparam int unsigned EVENT_W            = 3;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [7:0] KIND_DATA    = 8'h00;
  localparam logic [7:0] KIND_EOF     = 8'h01;
  localparam logic [7:0] KIND_SEGMENT = 8'h02;
  localparam logic [7:0] KIND_LINEAR  = 8'h04;
  localparam logic [7:0] EXT_LENGTH   = 8'h02;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_LEN     = 4'd1,
    PH_ADDR_HI = 4'd2,
    PH_ADDR_LO = 4'd3,
    PH_TYPE    = 4'd4,
    PH_DATA    = 4'd5,
    PH_CKSUM   = 4'd6,
    PH_SKIP    = 4'd7,
    PH_DONE    = 4'd8
  } phase_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_WRITE     = 3'd0,
    EV_SUCCESS   = 3'd1,
    EV_FORMAT    = 3'd2,
    EV_CHECKSUM  = 3'd3,
    EV_PREMATURE = 3'd4
  } event_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              end_of_stream;
  } item_t;

  typedef struct packed {
    logic                  emit;
    event_t                ev;
    logic [ADDR_OUT_W-1:0] address;
    logic [DATA_W-1:0]     data;
  } result_t;

  // Returns {valid, nibble} for one ASCII hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    begin
      r = 5'b0;
      if (c >= 8'h30 && c <= 8'h39) begin
        r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
    end
  endfunction

endpackage

@@ rtl/hex_record_loader_core.sv @@
// ----------------------------------------------------------------------------
// hex_record_loader_core
// Parses hexadecimal record text one character per transaction and issues
// byte writes, end-of-file success or error events.
// ----------------------------------------------------------------------------
// The block accepts one character per clock cycle when the result side is not
// stalled. Each character is captured in the input register, passes through
// the parser logic, and any result it causes is loaded into the result
// register, where it is held until the sink takes it. Characters that cause
// no result still pass through the input register and the parser. After a
// final event (success or any error) every further character is accepted
// and dropped until reset. Byte write addresses wrap at min(ADDRESS_WIDTH, 32)
// bits.
`timescale 1ns / 1ps

module hex_record_loader_core #(
  parameter int unsigned ADDRESS_WIDTH = hrl_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic [0:0]  in_tuser,   // [0] end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] address, [39:32] data
  output logic [2:0]  out_tuser   // [2:0] event_res
);
  import hrl_pkg::*;

  item_t   in_item;
  item_t   cur_item;
  logic    cur_valid;
  logic    slot_free;
  logic    step;
  result_t res;
  result_t res_q;

  assign in_item.character     = in_tdata;
  assign in_item.end_of_stream = in_tuser[0];

  assign step = cur_valid && slot_free;

  hrl_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .advance  (step),
    .valid    (cur_valid),
    .item     (cur_item)
  );

  hrl_parser #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (cur_item),
    .res   (res)
  );

  hrl_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res.emit),
    .res_in    (res),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .slot_free (slot_free),
    .res_out   (res_q)
  );

  assign out_tdata = {res_q.data, res_q.address};
  assign out_tuser = res_q.ev;

endmodule

@@ rtl/hrl_in_reg.sv @@
// ----------------------------------------------------------------------------
// hrl_in_reg
// Input register: captures one character transaction and holds it until the
// parser takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrl_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hrl_pkg::item_t in_item,
  input  logic          advance,
  output logic          valid,
  output hrl_pkg::item_t item
);
  import hrl_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

@@ rtl/hrl_parser.sv @@
// ----------------------------------------------------------------------------
// hrl_parser
// Record parser: holds the per-record state and turns one character into at
// most one result in combinational logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hex_record_loader_core_assert.svh"

module hrl_parser #(
  parameter int unsigned ADDRESS_WIDTH = hrl_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  hrl_pkg::item_t   item,
  output hrl_pkg::result_t res
);
  import hrl_pkg::*;

  localparam int unsigned AddrBits = (ADDRESS_WIDTH < 32) ? ADDRESS_WIDTH : 32;

  phase_t              phase_r,       phase_nxt;
  logic                low_next_r,    low_next_nxt;
  logic [3:0]          high_nib_r,    high_nib_nxt;
  logic [7:0]          rec_len_r,     rec_len_nxt;
  logic [7:0]          bytes_left_r,  bytes_left_nxt;
  logic [AddrBits-1:0] wr_addr_r,     wr_addr_nxt;
  logic [AddrBits-1:0] base_r,        base_nxt;
  logic [7:0]          sum_r,         sum_nxt;
  logic [7:0]          kind_r,        kind_nxt;
  logic [15:0]         base_field_r,  base_field_nxt;

  logic [4:0]  digit;
  logic [7:0]  byte_val;
  logic [31:0] wide_tmp;

  assign digit    = hex_digit(item.character);
  assign byte_val = {high_nib_r, digit[3:0]};

  always_comb begin
    phase_nxt      = phase_r;
    low_next_nxt   = low_next_r;
    high_nib_nxt   = high_nib_r;
    rec_len_nxt    = rec_len_r;
    bytes_left_nxt = bytes_left_r;
    wr_addr_nxt    = wr_addr_r;
    base_nxt       = base_r;
    sum_nxt        = sum_r;
    kind_nxt       = kind_r;
    base_field_nxt = base_field_r;
    wide_tmp       = '0;
    res            = '0;

    if (step && phase_r != PH_DONE) begin
      if (item.end_of_stream) begin
        res.emit  = 1'b1;
        res.ev    = EV_PREMATURE;
        phase_nxt = PH_DONE;
      end else if (phase_r == PH_START) begin
        if (item.character != CHAR_COLON) begin
          res.emit  = 1'b1;
          res.ev    = EV_FORMAT;
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt    = PH_LEN;
          sum_nxt      = '0;
          low_next_nxt = 1'b0;
        end
      end else if (phase_r == PH_SKIP) begin
        if (item.character == CHAR_NEWLINE) begin
          phase_nxt = PH_START;
        end
      end else if (!digit[4]) begin
        // Covers newlines and any other stray character inside a record.
        res.emit  = 1'b1;
        res.ev    = EV_FORMAT;
        phase_nxt = PH_DONE;
      end else if (!low_next_r) begin
        high_nib_nxt = digit[3:0];
        low_next_nxt = 1'b1;
      end else begin
        low_next_nxt = 1'b0;
        sum_nxt      = sum_r + byte_val;
        unique case (phase_r)
          PH_LEN: begin
            rec_len_nxt    = byte_val;
            bytes_left_nxt = byte_val;
            phase_nxt      = PH_ADDR_HI;
          end
          PH_ADDR_HI: begin
            wide_tmp    = {16'b0, byte_val, 8'b0};
            wr_addr_nxt = wide_tmp[AddrBits-1:0];
            phase_nxt   = PH_ADDR_LO;
          end
          PH_ADDR_LO: begin
            wr_addr_nxt = {wr_addr_r[AddrBits-1:8], byte_val} + base_r;
            phase_nxt   = PH_TYPE;
          end
          PH_TYPE: begin
            kind_nxt = byte_val;
            if (byte_val == KIND_EOF) begin
              res.emit  = 1'b1;
              res.ev    = EV_SUCCESS;
              phase_nxt = PH_DONE;
            end else if ((byte_val == KIND_SEGMENT || byte_val == KIND_LINEAR) &&
                         rec_len_r != EXT_LENGTH) begin
              res.emit  = 1'b1;
              res.ev    = EV_FORMAT;
              phase_nxt = PH_DONE;
            end else begin
              base_field_nxt = '0;
              phase_nxt      = (bytes_left_r != 8'd0) ? PH_DATA : PH_CKSUM;
            end
          end
          PH_DATA: begin
            if (kind_r == KIND_DATA) begin
              res.emit    = 1'b1;
              res.ev      = EV_WRITE;
              res.address = 32'(wr_addr_r);
              res.data    = byte_val;
              wr_addr_nxt = wr_addr_r + 1'b1;
            end else if (kind_r == KIND_SEGMENT || kind_r == KIND_LINEAR) begin
              base_field_nxt = {base_field_r[7:0], byte_val};
            end
            bytes_left_nxt = bytes_left_r - 8'd1;
            if (bytes_left_r == 8'd1) begin
              phase_nxt = PH_CKSUM;
            end
          end
          PH_CKSUM: begin
            if (sum_nxt != 8'd0) begin
              res.emit  = 1'b1;
              res.ev    = EV_CHECKSUM;
              phase_nxt = PH_DONE;
            end else begin
              if (kind_r == KIND_SEGMENT) begin
                wide_tmp = {12'b0, base_field_r, 4'b0};
                base_nxt = wide_tmp[AddrBits-1:0];
              end else if (kind_r == KIND_LINEAR) begin
                wide_tmp = {base_field_r, 16'b0};
                base_nxt = wide_tmp[AddrBits-1:0];
              end
              phase_nxt = PH_SKIP;
            end
          end
          default: begin
            res.emit  = 1'b1;
            res.ev    = EV_FORMAT;
            phase_nxt = PH_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      low_next_r   <= 1'b0;
      high_nib_r   <= '0;
      rec_len_r    <= '0;
      bytes_left_r <= '0;
      wr_addr_r    <= '0;
      base_r       <= '0;
      sum_r        <= '0;
      kind_r       <= '0;
      base_field_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      low_next_r   <= low_next_nxt;
      high_nib_r   <= high_nib_nxt;
      rec_len_r    <= rec_len_nxt;
      bytes_left_r <= bytes_left_nxt;
      wr_addr_r    <= wr_addr_nxt;
      base_r       <= base_nxt;
      sum_r        <= sum_nxt;
      kind_r       <= kind_nxt;
      base_field_r <= base_field_nxt;
    end
  end

  `HRL_ASSERT_NXT(a_done_sticks, phase_r == PH_DONE, phase_r == PH_DONE,
                  "parser left the finished state without reset")
  `HRL_ASSERT_NXT(a_final_ends, step && res.emit && res.ev != EV_WRITE,
                  phase_r == PH_DONE, "final event did not stop the parser")
  `HRL_ASSERT_IMP(a_write_in_data, step && res.emit && res.ev == EV_WRITE,
                  phase_r == PH_DATA && kind_r == KIND_DATA,
                  "byte write outside a data record body")
  `HRL_ASSERT_IMP(a_data_has_bytes, phase_r == PH_DATA, bytes_left_r != 8'd0,
                  "data phase entered with no bytes left")

endmodule

@@ rtl/hrl_out_reg.sv @@
// ----------------------------------------------------------------------------
// hrl_out_reg
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrl_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  hrl_pkg::result_t res_in,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             slot_free,
  output hrl_pkg::result_t res_out
);
  import hrl_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign slot_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule
